@@ rtl/core/assert_macros.svh @@
// Assertion macros used by the top level of the frame FIFO.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_NEVER(lbl, expr, msg) \
  `ASSERT_ALWAYS(lbl, !(expr), msg)
`else
`define ASSERT_ALWAYS(lbl, prop, msg)
`define ASSERT_NEVER(lbl, expr, msg)
`endif
`endif

@@ rtl/core/fatf_pkg.sv @@
// Package of the frame FIFO: sizes, codes, ring arithmetic and the store request type.
package fatf_pkg;

  localparam int DEPTH  = 4096;
  localparam int AW     = $clog2(DEPTH);
  localparam int CNT_W  = 12;
  localparam int DROP_W = 32;

  typedef logic [AW-1:0]     ptr_t;
  typedef logic [AW:0]       dist_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [DROP_W-1:0] drop_t;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  typedef enum logic [1:0] {
    STAT_NONE   = 2'd0,
    STAT_COMMIT = 2'd1,
    STAT_DROP   = 2'd2
  } frame_status_t;

  typedef struct packed {
    logic       we;
    ptr_t       waddr;
    logic [7:0] wdata;
    logic       re;
    ptr_t       raddr;
  } store_req_t;

  function automatic ptr_t ring_next(ptr_t p);
    if (p == ptr_t'(DEPTH - 1)) begin
      return '0;
    end
    return p + ptr_t'(1);
  endfunction

  function automatic ptr_t ring_dist(ptr_t from, ptr_t to);
    dist_t t;
    t = {1'b0, to} - {1'b0, from};
    if (to < from) begin
      t = t + dist_t'(DEPTH);
    end
    return t[AW-1:0];
  endfunction

  function automatic cnt_t to_count(ptr_t d);
    logic [31:0] w;
    w = 32'(d);
    return w[CNT_W-1:0];
  endfunction

endpackage

@@ rtl/core/fatf_ifs.sv @@
// Channel interfaces of the frame FIFO: request items in, result items out.
interface fatf_req_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] data;
  logic       last;

  modport source (output valid, output op, output data, output last, input ready);
  modport sink   (input valid, input op, input data, input last, output ready);
endinterface

interface fatf_rsp_if;
  import fatf_pkg::*;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       read_valid;
  logic [1:0] frame_status;
  cnt_t       stored_count;
  drop_t      drop_count;

  modport source (output valid, output read_data, output read_valid, output frame_status,
                  output stored_count, output drop_count, input ready);
  modport sink   (input valid, input read_data, input read_valid, input frame_status,
                  input stored_count, input drop_count, output ready);
endinterface

@@ rtl/core/fatf_store.sv @@
// Byte store of the frame FIFO: one write port and one registered read port.
module fatf_store (
  input  logic                clk,
  input  fatf_pkg::store_req_t req,
  output logic [7:0]          rdata
);
  import fatf_pkg::*;

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

@@ rtl/core/frame_atomic_tx_fifo_unit.sv @@
// Top level of the frame FIFO: pointer control, result staging and the byte store.
// The req channel carries one item per transfer: a push of one frame byte with its
// last-of-frame flag, or a pop of one committed byte. The rsp channel returns exactly
// one result per request, in order: the popped byte and its valid flag, the frame
// status (commit or drop on a last byte), the committed byte count and the drop count.
// Pushed bytes stay invisible to pops until the last byte of their frame commits them;
// a frame that runs out of space is discarded whole and counted as dropped.
// Throughput is one transfer per cycle on each side when neither side stalls. A result
// is offered from the output register: the pointers update in the accept cycle, and the
// byte store's read port is registered alongside the staging register.
// A staging register and the output register hold two results between the sides,
// so the req side keeps accepting while one finished result waits to be taken.
// When the receiver stalls, req.ready falls once both registers are full and rises
// again in the cycle the result is taken.
// Reset clears the pointers, the discard flag, the drop count and the staging and output
// valid flags; the byte store is not cleared, since only written bytes are read.
`include "assert_macros.svh"
module frame_atomic_tx_fifo_unit (
  input  logic        clk,
  input  logic        rst,
  fatf_req_if.sink    req,
  fatf_rsp_if.source  rsp
);
  import fatf_pkg::*;

  ptr_t  committed_head, committed_head_next;
  ptr_t  pending_head, pending_head_next;
  ptr_t  read_tail, read_tail_next;
  logic  discarding, discarding_next;
  drop_t dropped_frames, dropped_frames_next;

  frame_status_t status_next;
  logic          pop_hit;
  store_req_t    store_req;
  logic [7:0]    store_q;

  logic          pend;
  logic          pend_hit;
  frame_status_t pend_status;
  cnt_t          pend_count;
  drop_t         pend_drop;

  logic accept;
  logic out_free;

  assign out_free  = !rsp.valid || rsp.ready;
  assign req.ready = !pend || out_free;
  assign accept    = req.valid && req.ready;

  always_comb begin
    committed_head_next = committed_head;
    pending_head_next   = pending_head;
    read_tail_next      = read_tail;
    discarding_next     = discarding;
    dropped_frames_next = dropped_frames;
    status_next         = STAT_NONE;
    pop_hit             = 1'b0;
    store_req           = '0;
    store_req.waddr     = pending_head;
    store_req.wdata     = req.data;
    store_req.raddr     = read_tail;
    if (req.op == OP_PUSH) begin
      if (!discarding) begin
        if (ring_dist(read_tail, pending_head) < ptr_t'(DEPTH - 1)) begin
          store_req.we      = accept;
          pending_head_next = ring_next(pending_head);
        end else begin
          discarding_next   = 1'b1;
          pending_head_next = committed_head;
        end
      end
      if (req.last) begin
        if (discarding_next) begin
          dropped_frames_next = dropped_frames + drop_t'(1);
          pending_head_next   = committed_head;
          discarding_next     = 1'b0;
          status_next         = STAT_DROP;
        end else begin
          committed_head_next = pending_head_next;
          status_next         = STAT_COMMIT;
        end
      end
    end else if (committed_head != read_tail) begin
      store_req.re   = accept;
      pop_hit        = 1'b1;
      read_tail_next = ring_next(read_tail);
    end
  end

  fatf_store u_store (
    .clk   (clk),
    .req   (store_req),
    .rdata (store_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      committed_head <= '0;
      pending_head   <= '0;
      read_tail      <= '0;
      discarding     <= 1'b0;
      dropped_frames <= '0;
    end else if (accept) begin
      committed_head <= committed_head_next;
      pending_head   <= pending_head_next;
      read_tail      <= read_tail_next;
      discarding     <= discarding_next;
      dropped_frames <= dropped_frames_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else if (accept) begin
      pend <= 1'b1;
    end else if (out_free) begin
      pend <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_hit    <= pop_hit;
      pend_status <= status_next;
      pend_count  <= to_count(ring_dist(read_tail_next, committed_head_next));
      pend_drop   <= dropped_frames_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (pend && out_free) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pend && out_free) begin
      rsp.read_data    <= pend_hit ? store_q : 8'h00;
      rsp.read_valid   <= pend_hit;
      rsp.frame_status <= pend_status;
      rsp.stored_count <= pend_count;
      rsp.drop_count   <= pend_drop;
    end
  end

  `ASSERT_ALWAYS(a_discard_no_pending, discarding |-> (pending_head == committed_head), "discarding frame still holds pending bytes")
  `ASSERT_NEVER(a_pop_with_status, rsp.valid && rsp.read_valid && (rsp.frame_status != STAT_NONE), "pop result reports a frame status")
  `ASSERT_ALWAYS(a_stalled_stage_holds, (pend && !out_free) |=> pend, "staged result lost while output stalled")
  `ASSERT_ALWAYS(a_not_ready_means_full, !req.ready |-> (pend && rsp.valid), "request side stalled with free staging")
  `ASSERT_ALWAYS(a_drop_steps_by_one, (dropped_frames != $past(dropped_frames)) |-> (dropped_frames == $past(dropped_frames) + drop_t'(1)), "drop count moved by more than one")

endmodule

@@ test/fatf_frame_checker.sv @@
`timescale 1ns / 1ps
// Scoreboard of the frame FIFO: predicts the result of each request transfer and checks it.
module fatf_frame_checker
  import fatf_pkg::*;
(
  input  logic clk,
  input  logic rst,
  fatf_req_if  req,
  fatf_rsp_if  rsp,
  output int   errors,
  output int   outstanding
);

  typedef struct {
    logic [7:0]    read_data;
    logic          read_valid;
    frame_status_t frame_status;
    cnt_t          stored_count;
    drop_t         drop_count;
  } fifo_result_t;

  logic [7:0]   ring_bytes [DEPTH];
  int           committed_end;
  int           pending_end;
  int           oldest;
  bit           overflowed;
  drop_t        frames_dropped;
  fifo_result_t expected_results [$];

  function automatic int used_span(int from, int to);
    return (to >= from) ? to - from : DEPTH - (from - to);
  endfunction

  function automatic int step_index(int idx);
    return (idx + 1) % DEPTH;
  endfunction

  function automatic fifo_result_t predict_fifo_result(logic op, logic [7:0] data, logic last);
    fifo_result_t r;
    r.read_data    = '0;
    r.read_valid   = 1'b0;
    r.frame_status = STAT_NONE;
    if (op == OP_PUSH) begin
      if (!overflowed) begin
        if (used_span(oldest, pending_end) < DEPTH - 1) begin
          ring_bytes[pending_end] = data;
          pending_end = step_index(pending_end);
        end else begin
          overflowed  = 1'b1;
          pending_end = committed_end;
        end
      end
      if (last) begin
        if (overflowed) begin
          frames_dropped = frames_dropped + drop_t'(1);
          pending_end    = committed_end;
          overflowed     = 1'b0;
          r.frame_status = STAT_DROP;
        end else begin
          committed_end  = pending_end;
          r.frame_status = STAT_COMMIT;
        end
      end
    end else if (committed_end != oldest) begin
      r.read_data  = ring_bytes[oldest];
      r.read_valid = 1'b1;
      oldest = step_index(oldest);
    end
    r.stored_count = cnt_t'(used_span(oldest, committed_end));
    r.drop_count   = frames_dropped;
    return r;
  endfunction

  task automatic compare_field(string field, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", field, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    fifo_result_t want;
    if (rst) begin
      committed_end  = 0;
      pending_end    = 0;
      oldest         = 0;
      overflowed     = 1'b0;
      frames_dropped = '0;
      errors         = 0;
      expected_results.delete();
    end else begin
      if (req.valid && req.ready) begin
        expected_results.push_back(predict_fifo_result(req.op, req.data, req.last));
      end
      if (rsp.valid && rsp.ready) begin
        if (expected_results.size() == 0) begin
          $error("result transfer with no request outstanding");
          errors++;
        end else begin
          want = expected_results.pop_front();
          compare_field("read_data", 32'(want.read_data), 32'(rsp.read_data));
          compare_field("read_valid", 32'(want.read_valid), 32'(rsp.read_valid));
          compare_field("frame_status", 32'(want.frame_status), 32'(rsp.frame_status));
          compare_field("stored_count", 32'(want.stored_count), 32'(rsp.stored_count));
          compare_field("drop_count", 32'(want.drop_count), 32'(rsp.drop_count));
        end
      end
    end
    outstanding <= expected_results.size();
  end

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps
// Testbench top of the frame FIFO: clock, reset, request stimulus, result back-pressure and verdict.
module tb;
  import fatf_pkg::*;

  logic clk;
  logic rst;
  int   send_idle = 13;
  int   recv_idle = 67;
  int   hold_cycles = 0;
  int   hold_at = 0;
  bit   hold_done = 1'b0;
  int   sent_count = 0;
  int   fail_count;
  int   outstanding;

  fatf_req_if req_ch ();
  fatf_rsp_if rsp_ch ();

  frame_atomic_tx_fifo_unit u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  fatf_frame_checker u_check (
    .clk         (clk),
    .rst         (rst),
    .req         (req_ch),
    .rsp         (rsp_ch),
    .errors      (fail_count),
    .outstanding (outstanding)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    #20_000_000;
    $display("FAIL");
    $finish;
  end

  // The receiver counts its own long hold-off once the sender has passed the set mark.
  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!hold_done && hold_at != 0 && sent_count >= hold_at) begin
        hold_cycles = 500;
        hold_done   = 1'b1;
      end
      if (rst) begin
        rsp_ch.ready = 1'b0;
      end else if (hold_cycles > 0) begin
        rsp_ch.ready = 1'b0;
        hold_cycles--;
      end else begin
        rsp_ch.ready = ($urandom_range(99) >= recv_idle);
      end
    end
  end

  task automatic send_req(logic op, logic [7:0] data, logic last);
    while ($urandom_range(99) < send_idle) begin
      req_ch.valid = 1'b0;
      req_ch.data  = 8'($urandom);
      @(negedge clk);
    end
    req_ch.valid = 1'b1;
    req_ch.op    = op;
    req_ch.data  = data;
    req_ch.last  = last;
    do begin
      @(posedge clk);
    end while (!req_ch.ready);
    sent_count++;
    @(negedge clk);
  endtask

  task automatic pop_bytes(int n);
    repeat (n) send_req(OP_POP, 8'($urandom), 1'($urandom));
  endtask

  task automatic push_frame(int len, int pop_pct);
    int k;
    for (k = 0; k < len; k++) begin
      send_req(OP_PUSH, 8'($urandom), k == len - 1);
      if (k < len - 1 && $urandom_range(99) < pop_pct) begin
        pop_bytes(1);
      end
    end
  endtask

  task automatic random_phase(int n_items);
    int stop_at;
    int len;
    stop_at = sent_count + n_items;
    while (sent_count < stop_at) begin
      if ($urandom_range(99) < 70) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
        push_frame(len, 25);
      end else begin
        pop_bytes($urandom_range(1, 4));
      end
    end
  endtask

  task automatic wait_drained();
    req_ch.valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  initial begin
    rst          = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.op    = OP_PUSH;
    req_ch.data  = '0;
    req_ch.last  = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send_req(OP_POP, 8'hFF, 1'b1);
    send_req(OP_PUSH, 8'h00, 1'b1);
    send_req(OP_POP, 8'h00, 1'b0);
    send_req(OP_POP, 8'h00, 1'b0);
    send_req(OP_PUSH, 8'hFF, 1'b0);
    send_req(OP_PUSH, 8'h00, 1'b0);
    send_req(OP_PUSH, 8'h5A, 1'b0);
    send_req(OP_PUSH, 8'hA5, 1'b1);
    send_req(OP_PUSH, 8'h11, 1'b0);
    send_req(OP_POP, 8'hAA, 1'b1);
    send_req(OP_POP, 8'h55, 1'b0);
    send_req(OP_PUSH, 8'h22, 1'b1);
    send_req(OP_PUSH, 8'h80, 1'b0);
    send_req(OP_PUSH, 8'h01, 1'b1);
    pop_bytes(8);

    hold_at = sent_count + 200;
    random_phase(530);
    wait_drained();
    repeat (4) @(negedge clk);

    send_idle = 67;
    recv_idle = 13;
    random_phase(530);
    wait_drained();

    send_idle = 0;
    recv_idle = 0;
    random_phase(540);

    wait_drained();
    repeat (6) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
